>>> rtl/core/prbq_pkg.sv
package prbq_pkg;

  localparam int ID_SLOTS      = 16;
  localparam int MAX_PROCS_DEF = 16;
  localparam int ACT_W         = 3;
  localparam int ID_W          = 4;
  localparam int PRIO_W        = 8;
  localparam int STAT_W        = 2;
  localparam int CNT_W         = 5;
  // List addresses are carried at the width that covers every id slot.
  localparam int SLOT_W        = 4;

  typedef enum logic [ACT_W-1:0] {
    ACT_INSERT  = 3'd0,
    ACT_REMOVE  = 3'd1,
    ACT_UNBLOCK = 3'd2,
    ACT_PICK    = 3'd3,
    ACT_SUSPEND = 3'd4
  } action_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK            = 2'd0,
    ST_NOT_QUEUED    = 2'd1,
    ST_FULL_DUP      = 2'd2,
    ST_NONE_RUNNABLE = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    WQ_NONE    = 2'd0,
    WQ_READY   = 2'd1,
    WQ_BLOCKED = 2'd2
  } where_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RINS,
    S_RDROP,
    S_BDROP,
    S_PICK,
    S_FIN
  } state_t;

  // Write and read controls from the sequencer to the list storage.
  typedef struct packed {
    logic                     rl_we;
    logic [SLOT_W-1:0]        rl_waddr;
    logic [ID_W-1:0]          rl_wid;
    logic signed [PRIO_W-1:0] rl_wprio;
    logic [SLOT_W-1:0]        rl_raddr;
    logic                     bl_we;
    logic [SLOT_W-1:0]        bl_waddr;
    logic [ID_W-1:0]          bl_wid;
    logic [SLOT_W-1:0]        bl_raddr;
  } store_cmd_t;

  typedef struct packed {
    logic [ID_W-1:0]          rl_id;
    logic signed [PRIO_W-1:0] rl_prio;
    logic [ID_W-1:0]          bl_id;
  } store_rd_t;

  typedef struct packed {
    status_t          status;
    logic             next_valid;
    logic [ID_W-1:0]  next_id;
    logic [CNT_W-1:0] ready_count;
    logic [CNT_W-1:0] blocked_count;
  } result_t;

endpackage

>>> rtl/core/prbq_if.sv
interface prbq_in_if import prbq_pkg::*;;
  logic                     valid;
  logic                     ready;
  logic [ACT_W-1:0]         action;
  logic [ID_W-1:0]          proc_id;
  logic signed [PRIO_W-1:0] priority_req;
  logic                     to_blocked;
  logic                     suspend_flag;

  modport source (output valid, action, proc_id, priority_req, to_blocked, suspend_flag,
                  input ready);
  modport sink (input valid, action, proc_id, priority_req, to_blocked, suspend_flag,
                output ready);
endinterface

interface prbq_out_if import prbq_pkg::*;;
  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] status;
  logic              next_valid;
  logic [ID_W-1:0]   next_id;
  logic [CNT_W-1:0]  ready_count;
  logic [CNT_W-1:0]  blocked_count;

  modport source (output valid, status, next_valid, next_id, ready_count, blocked_count,
                  input ready);
  modport sink (input valid, status, next_valid, next_id, ready_count, blocked_count,
                output ready);
endinterface

>>> rtl/core/priority_ready_blocked_queue.sv
// Scheduler tables for up to MAX_PROCS process ids: a ready list sorted by
// descending signed priority (equal priorities stay in arrival order) and a
// blocked list in arrival order. Each input beat carries one action (insert,
// remove, unblock, pick next, set suspended mark) and yields exactly one
// output beat with a status, the picked id and both list counts. A small
// sequencer walks the lists one entry per cycle through a single read and
// write port per list, and takes no new beat while it works. A beat is
// accepted, then the lists are walked, then the result goes to the output
// register. Insert into the blocked list, suspend, unknown actions and
// rejected requests have no walk. Insert into the ready list walks from the
// tail to the insertion point. Remove walks the whole holding list. Unblock
// walks the blocked list and then inserts into the ready list. Pick walks
// from the head to the first runnable entry or the end of the list. The
// output register lets a finished result wait for the consumer while the
// block takes the next input beat.
module priority_ready_blocked_queue import prbq_pkg::*; #(
  parameter int MAX_PROCS = MAX_PROCS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  prbq_in_if.sink    in_ch,
  prbq_out_if.source out_ch
);

  // Ids are only four bits wide, so no list ever holds more than all sixteen
  // ids; the storage is cut to that size for larger MAX_PROCS settings.
  localparam int LIST_DEPTH = (MAX_PROCS < ID_SLOTS) ? MAX_PROCS : ID_SLOTS;

  store_cmd_t cmd;
  store_rd_t  rd;
  logic       res_valid;
  logic       res_take;
  result_t    res;
  logic       out_valid_r;
  result_t    out_res_r;

  prbq_seq #(
    .MAX_PROCS (MAX_PROCS),
    .LIST_DEPTH(LIST_DEPTH)
  ) u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .cmd      (cmd),
    .rd       (rd),
    .res_valid(res_valid),
    .res_take (res_take),
    .res      (res)
  );

  prbq_store #(
    .LIST_DEPTH(LIST_DEPTH)
  ) u_store (
    .clk(clk),
    .cmd(cmd),
    .rd (rd)
  );

  // The output register takes a new result when it is empty or when its
  // current beat is being taken in the same cycle.
  assign res_take = !out_valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid && res_take) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_take) begin
      out_res_r <= res;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.status        = out_res_r.status;
  assign out_ch.next_valid    = out_res_r.next_valid;
  assign out_ch.next_id       = out_res_r.next_id;
  assign out_ch.ready_count   = out_res_r.ready_count;
  assign out_ch.blocked_count = out_res_r.blocked_count;

endmodule

>>> rtl/core/prbq_store.sv
module prbq_store import prbq_pkg::*; #(
  parameter int LIST_DEPTH = MAX_PROCS_DEF
) (
  input  logic       clk,
  input  store_cmd_t cmd,
  output store_rd_t  rd
);

  localparam int IDX_W = $clog2(LIST_DEPTH);

  logic [ID_W-1:0]          rl_id_r   [LIST_DEPTH];
  logic signed [PRIO_W-1:0] rl_prio_r [LIST_DEPTH];
  logic [ID_W-1:0]          bl_id_r   [LIST_DEPTH];

  // One write port and one read port on each list.
  always_ff @(posedge clk) begin
    if (cmd.rl_we) begin
      rl_id_r[cmd.rl_waddr[IDX_W-1:0]]   <= cmd.rl_wid;
      rl_prio_r[cmd.rl_waddr[IDX_W-1:0]] <= cmd.rl_wprio;
    end
    if (cmd.bl_we) begin
      bl_id_r[cmd.bl_waddr[IDX_W-1:0]] <= cmd.bl_wid;
    end
  end

  assign rd.rl_id   = rl_id_r[cmd.rl_raddr[IDX_W-1:0]];
  assign rd.rl_prio = rl_prio_r[cmd.rl_raddr[IDX_W-1:0]];
  assign rd.bl_id   = bl_id_r[cmd.bl_raddr[IDX_W-1:0]];

endmodule

>>> rtl/core/prbq_seq.sv
module prbq_seq import prbq_pkg::*; #(
  parameter int MAX_PROCS  = MAX_PROCS_DEF,
  parameter int LIST_DEPTH = MAX_PROCS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  prbq_in_if.sink    in_ch,
  output store_cmd_t cmd,
  input  store_rd_t  rd,
  output logic       res_valid,
  input  logic       res_take,
  output result_t    res
);

  localparam int LEN_W = $clog2(LIST_DEPTH + 1);
  localparam logic [LEN_W-1:0] FULL_LEN = LEN_W'(LIST_DEPTH);
  localparam logic [LEN_W-1:0] ONE_LEN  = LEN_W'(1);

  state_t                   state_r, state_nxt;
  logic [LEN_W-1:0]         rlen_r, rlen_nxt;
  logic [LEN_W-1:0]         blen_r, blen_nxt;
  logic [LEN_W-1:0]         ptr_r, ptr_nxt;
  logic [ID_W-1:0]          id_r, id_nxt;
  logic signed [PRIO_W-1:0] prio_r, prio_nxt;
  logic                     found_r, found_nxt;
  logic                     unblk_r, unblk_nxt;
  status_t                  status_r, status_nxt;
  logic                     nvalid_r, nvalid_nxt;
  logic [ID_W-1:0]          nid_r, nid_nxt;

  where_t                   where_r [ID_SLOTS];
  logic                     susp_r  [ID_SLOTS];
  logic signed [PRIO_W-1:0] held_r  [ID_SLOTS];

  logic            where_we;
  logic [ID_W-1:0] where_wid;
  where_t          where_wval;
  logic            susp_we;
  logic            held_we;
  action_t         in_act;
  logic            in_id_ok;
  where_t          in_where;

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_act      = action_t'(in_ch.action);
  assign in_id_ok    = (int'(in_ch.proc_id) < MAX_PROCS);
  assign in_where    = where_r[in_ch.proc_id];

  always_comb begin
    state_nxt  = state_r;
    rlen_nxt   = rlen_r;
    blen_nxt   = blen_r;
    ptr_nxt    = ptr_r;
    id_nxt     = id_r;
    prio_nxt   = prio_r;
    found_nxt  = found_r;
    unblk_nxt  = unblk_r;
    status_nxt = status_r;
    nvalid_nxt = nvalid_r;
    nid_nxt    = nid_r;
    cmd        = '0;
    where_we   = 1'b0;
    where_wid  = id_r;
    where_wval = WQ_NONE;
    susp_we    = 1'b0;
    held_we    = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          id_nxt     = in_ch.proc_id;
          prio_nxt   = in_ch.priority_req;
          status_nxt = ST_OK;
          nvalid_nxt = 1'b0;
          nid_nxt    = '0;
          ptr_nxt    = '0;
          found_nxt  = 1'b0;
          unblk_nxt  = 1'b0;
          state_nxt  = S_FIN;
          case (in_act)
            ACT_INSERT: begin
              if (!in_id_ok || in_where != WQ_NONE) begin
                status_nxt = ST_FULL_DUP;
              end else if (in_ch.to_blocked) begin
                if (blen_r == FULL_LEN) begin
                  status_nxt = ST_FULL_DUP;
                end else begin
                  cmd.bl_we    = 1'b1;
                  cmd.bl_waddr = SLOT_W'(blen_r);
                  cmd.bl_wid   = in_ch.proc_id;
                  blen_nxt     = blen_r + ONE_LEN;
                  where_we     = 1'b1;
                  where_wid    = in_ch.proc_id;
                  where_wval   = WQ_BLOCKED;
                  held_we      = 1'b1;
                end
              end else if (rlen_r == FULL_LEN) begin
                status_nxt = ST_FULL_DUP;
              end else begin
                held_we   = 1'b1;
                ptr_nxt   = rlen_r;
                state_nxt = S_RINS;
              end
            end
            ACT_REMOVE: begin
              if (!in_id_ok || in_where == WQ_NONE) begin
                status_nxt = ST_NOT_QUEUED;
              end else if (in_where == WQ_READY) begin
                state_nxt = S_RDROP;
              end else begin
                state_nxt = S_BDROP;
              end
            end
            ACT_UNBLOCK: begin
              if (!in_id_ok || in_where != WQ_BLOCKED) begin
                status_nxt = ST_NOT_QUEUED;
              end else begin
                prio_nxt  = held_r[in_ch.proc_id];
                unblk_nxt = 1'b1;
                state_nxt = S_BDROP;
              end
            end
            ACT_PICK: begin
              status_nxt = ST_NONE_RUNNABLE;
              state_nxt  = S_PICK;
            end
            ACT_SUSPEND: begin
              if (!in_id_ok) begin
                status_nxt = ST_NOT_QUEUED;
              end else begin
                susp_we = 1'b1;
              end
            end
            default: begin
            end
          endcase
        end
      end
      // Walk down from the tail, moving lower priorities up one slot.
      S_RINS: begin
        cmd.rl_raddr = SLOT_W'(ptr_r - ONE_LEN);
        cmd.rl_we    = 1'b1;
        cmd.rl_waddr = SLOT_W'(ptr_r);
        if (ptr_r == '0 || rd.rl_prio >= prio_r) begin
          cmd.rl_wid   = id_r;
          cmd.rl_wprio = prio_r;
          rlen_nxt     = rlen_r + ONE_LEN;
          where_we     = 1'b1;
          where_wval   = WQ_READY;
          state_nxt    = S_FIN;
        end else begin
          cmd.rl_wid   = rd.rl_id;
          cmd.rl_wprio = rd.rl_prio;
          ptr_nxt      = ptr_r - ONE_LEN;
        end
      end
      // Walk up from the head; entries past the match shift down one slot.
      S_RDROP: begin
        cmd.rl_raddr = SLOT_W'(ptr_r);
        if (found_r) begin
          cmd.rl_we    = 1'b1;
          cmd.rl_waddr = SLOT_W'(ptr_r - ONE_LEN);
          cmd.rl_wid   = rd.rl_id;
          cmd.rl_wprio = rd.rl_prio;
        end
        if (rd.rl_id == id_r) begin
          found_nxt = 1'b1;
        end
        if (LEN_W'(ptr_r + ONE_LEN) == rlen_r) begin
          rlen_nxt  = rlen_r - ONE_LEN;
          where_we  = 1'b1;
          state_nxt = S_FIN;
        end else begin
          ptr_nxt = ptr_r + ONE_LEN;
        end
      end
      S_BDROP: begin
        cmd.bl_raddr = SLOT_W'(ptr_r);
        if (found_r) begin
          cmd.bl_we    = 1'b1;
          cmd.bl_waddr = SLOT_W'(ptr_r - ONE_LEN);
          cmd.bl_wid   = rd.bl_id;
        end
        if (rd.bl_id == id_r) begin
          found_nxt = 1'b1;
        end
        if (LEN_W'(ptr_r + ONE_LEN) == blen_r) begin
          blen_nxt = blen_r - ONE_LEN;
          where_we = 1'b1;
          if (unblk_r) begin
            ptr_nxt   = rlen_r;
            state_nxt = S_RINS;
          end else begin
            state_nxt = S_FIN;
          end
        end else begin
          ptr_nxt = ptr_r + ONE_LEN;
        end
      end
      S_PICK: begin
        cmd.rl_raddr = SLOT_W'(ptr_r);
        if (ptr_r == rlen_r) begin
          state_nxt = S_FIN;
        end else if (!susp_r[rd.rl_id]) begin
          status_nxt = ST_OK;
          nvalid_nxt = 1'b1;
          nid_nxt    = rd.rl_id;
          state_nxt  = S_FIN;
        end else begin
          ptr_nxt = ptr_r + ONE_LEN;
        end
      end
      S_FIN: begin
        if (res_take) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      rlen_r  <= '0;
      blen_r  <= '0;
      for (int i = 0; i < ID_SLOTS; i++) begin
        where_r[i] <= WQ_NONE;
        susp_r[i]  <= 1'b0;
      end
    end else begin
      state_r <= state_nxt;
      rlen_r  <= rlen_nxt;
      blen_r  <= blen_nxt;
      if (where_we) begin
        where_r[where_wid] <= where_wval;
      end
      if (susp_we) begin
        susp_r[in_ch.proc_id] <= in_ch.suspend_flag;
      end
    end
  end

  always_ff @(posedge clk) begin
    ptr_r    <= ptr_nxt;
    id_r     <= id_nxt;
    prio_r   <= prio_nxt;
    found_r  <= found_nxt;
    unblk_r  <= unblk_nxt;
    status_r <= status_nxt;
    nvalid_r <= nvalid_nxt;
    nid_r    <= nid_nxt;
    if (held_we) begin
      held_r[in_ch.proc_id] <= in_ch.priority_req;
    end
  end

  assign res_valid         = (state_r == S_FIN);
  assign res.status        = status_r;
  assign res.next_valid    = nvalid_r;
  assign res.next_id       = nid_r;
  assign res.ready_count   = CNT_W'(rlen_r);
  assign res.blocked_count = CNT_W'(blen_r);

  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    rlen_r <= FULL_LEN && blen_r <= FULL_LEN)
    else $error("list length beyond storage depth");

  a_len_step: assert property (@(posedge clk) disable iff (!rst_n)
    1'b1 |=> (rlen_r == $past(rlen_r) || rlen_r == LEN_W'($past(rlen_r) + ONE_LEN)
              || LEN_W'(rlen_r + ONE_LEN) == $past(rlen_r)))
    else $error("ready length moved by more than one entry");

  a_pick_ok: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_FIN && nvalid_r |-> status_r == ST_OK)
    else $error("picked id reported with a failing status");

  a_fin_leave: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_FIN && res_take |=> state_r == S_IDLE)
    else $error("result handed over but sequencer did not return to idle");

endmodule
